@@ hdl/wsip_pkg.sv @@
package wsip_pkg;

  localparam int SAMPLES_PER_PERIOD = 8;
  localparam int SPP_SHIFT          = $clog2(SAMPLES_PER_PERIOD);

  localparam int COUNT_W = 16;
  localparam int SPEED_W = 13;
  localparam int ERR_W   = 14;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int DRIVE_W = 17;
  localparam int GAIN_W  = 16;
  localparam int MIX_W   = 28;
  localparam int OLD_W   = 25;
  localparam int ACC_W   = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SPEED_MAX   = 4095;
  localparam int SPEED_MIN   = -4096;
  localparam int DRIVE_LIMIT = 55705;

  localparam logic [14:0] W_NEW     = 15'd29491;
  localparam logic [11:0] W_OLD     = 12'd3277;
  localparam int          Q15_SHIFT = 15;
  localparam int          Q15_ONE   = 32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
  } wsip_gains_t;

  typedef struct packed {
    logic signed [MIX_W-1:0]   new_term;
    logic signed [SPEED_W-1:0] target;
  } wsip_s1_t;

endpackage

@@ hdl/wsip_front.sv @@
module wsip_front
  import wsip_pkg::*;
(
  input  logic                      clk,
  input  logic                      load,
  input  logic signed [COUNT_W-1:0] left_count_sum,
  input  logic signed [COUNT_W-1:0] right_count_sum,
  input  logic signed [SPEED_W-1:0] speed_goal,
  output wsip_s1_t                  s1_data_r
);

  localparam int CW1  = COUNT_W + 1;
  localparam int SUMW = CW1 + 1;
  localparam logic signed [SUMW-1:0] AVG_HI = SUMW'(SPEED_MAX);
  localparam logic signed [SUMW-1:0] AVG_LO = SUMW'(SPEED_MIN);

  logic signed [CW1-1:0]     l_bias, r_bias, l_q, r_q;
  logic signed [SUMW-1:0]    wheel_sum, sum_bias, half;
  logic signed [SPEED_W-1:0] avg;
  wsip_s1_t                  s1_data_nxt;

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    l_bias = CW1'(left_count_sum)
           + (left_count_sum[COUNT_W-1] ? CW1'(SAMPLES_PER_PERIOD - 1) : '0);
    r_bias = CW1'(right_count_sum)
           + (right_count_sum[COUNT_W-1] ? CW1'(SAMPLES_PER_PERIOD - 1) : '0);
    l_q = l_bias >>> SPP_SHIFT;
    r_q = r_bias >>> SPP_SHIFT;
    wheel_sum = SUMW'(l_q) + SUMW'(r_q);
    sum_bias  = wheel_sum + (wheel_sum[SUMW-1] ? SUMW'(1) : '0);
    half      = sum_bias >>> 1;
    if (half > AVG_HI) begin
      avg = SPEED_W'(SPEED_MAX);
    end else if (half < AVG_LO) begin
      avg = SPEED_W'(SPEED_MIN);
    end else begin
      avg = half[SPEED_W-1:0];
    end
    s1_data_nxt.new_term = MIX_W'(avg) * MIX_W'($signed({1'b0, W_NEW}));
    s1_data_nxt.target   = speed_goal;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_data_r <= s1_data_nxt;
    end
  end

endmodule

@@ hdl/wsip_core.sv @@
module wsip_core
  import wsip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  wsip_s1_t                  s1_data,
  input  wsip_gains_t               gains,
  output logic signed [DRIVE_W-1:0] drive_r,
  output logic signed [SPEED_W-1:0] speed_r,
  output logic                      sat_r
);

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(DRIVE_LIMIT);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(DRIVE_LIMIT);

  // old_term_r holds W_OLD * filtered speed, so the filter needs no multiply here
  logic signed [OLD_W-1:0]   old_term_r, old_term_nxt;
  logic signed [ERR_W-1:0]   prev_err_r, err;
  logic signed [DRIVE_W-1:0] acc_r, acc_nxt;
  logic                      sat_nxt;
  logic signed [MIX_W-1:0]   mix, mix_bias, mix_sh;
  logic signed [SPEED_W-1:0] f;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ACC_W-1:0]   p_term, i_term, acc_sum;

  always_comb begin
    mix      = s1_data.new_term + MIX_W'(old_term_r);
    mix_bias = mix + (mix[MIX_W-1] ? MIX_W'(Q15_ONE - 1) : '0);
    mix_sh   = mix_bias >>> Q15_SHIFT;
    f        = mix_sh[SPEED_W-1:0];
    err      = ERR_W'(s1_data.target) - ERR_W'(f);
    diff     = DIFF_W'(err) - DIFF_W'(prev_err_r);
    p_term   = ACC_W'($signed({1'b0, gains.prop})) * ACC_W'(diff);
    i_term   = ACC_W'($signed({1'b0, gains.integ})) * ACC_W'(err);
    acc_sum  = ACC_W'(acc_r) + p_term + i_term;
    if (acc_sum > ACC_HI) begin
      acc_nxt = DRIVE_W'(DRIVE_LIMIT);
      sat_nxt = 1'b1;
    end else if (acc_sum < ACC_LO) begin
      acc_nxt = -DRIVE_W'(DRIVE_LIMIT);
      sat_nxt = 1'b1;
    end else begin
      acc_nxt = acc_sum[DRIVE_W-1:0];
      sat_nxt = 1'b0;
    end
    old_term_nxt = OLD_W'(f) * OLD_W'($signed({1'b0, W_OLD}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_term_r <= '0;
      prev_err_r <= '0;
      acc_r      <= '0;
    end else if (fire) begin
      old_term_r <= old_term_nxt;
      prev_err_r <= err;
      acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r <= acc_nxt;
      speed_r <= f;
      sat_r   <= sat_nxt;
    end
  end

endmodule

@@ hdl/wheel_speed_incremental_pi_unit.sv @@
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_ready  | left_count_sum, right_count_sum, speed_goal
// out      | out_valid/out_ready| drive_out, measured_speed, saturated
// cfg      | cfg_wr_en          | cfg_index, cfg_wdata (0 prop_gain, 1 integ_gain)
//
// Requests pass the stage 1, then stage 2 registers; one request per cycle with no stall.
// Stage 1 does wheel averaging and the new-sample filter product; stage 2 closes
// the filter and PI loop through the state registers.
// Reset (rst_n low, synchronous) clears gains, filter, error and drive state.
// A stalled output holds both stages; the input is still taken while stage 1 is empty.
module wheel_speed_incremental_pi_unit
  import wsip_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COUNT_W-1:0]    in_left_count_sum,
  input  logic signed [COUNT_W-1:0]    in_right_count_sum,
  input  logic signed [SPEED_W-1:0]    in_speed_goal,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DRIVE_W-1:0]    out_drive_out,
  output logic signed [SPEED_W-1:0]    out_measured_speed,
  output logic                         out_saturated
);

  wsip_gains_t gains_r;
  wsip_s1_t    s1_data;
  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        advance, s1_load, fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:  gains_r.prop  <= cfg_wdata[GAIN_W-1:0];
        CFG_INTEG_GAIN: gains_r.integ <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    advance  = !out_valid_r || out_ready;
    in_ready = rst_n && (!s1_valid_r || advance);
    s1_load  = in_valid && in_ready;
    fire     = s1_valid_r && advance;

    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  wsip_front u_front (
    .clk             (clk),
    .load            (s1_load),
    .left_count_sum  (in_left_count_sum),
    .right_count_sum (in_right_count_sum),
    .speed_goal      (in_speed_goal),
    .s1_data_r       (s1_data)
  );

  wsip_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .s1_data (s1_data),
    .gains   (gains_r),
    .drive_r (out_drive_out),
    .speed_r (out_measured_speed),
    .sat_r   (out_saturated)
  );

`ifndef ASSERT_OFF
  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_out <= DRIVE_W'(DRIVE_LIMIT)) &&
                    (out_drive_out >= -DRIVE_W'(DRIVE_LIMIT)))
    else $error("drive outside limit");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_saturated) |->
      (out_drive_out == DRIVE_W'(DRIVE_LIMIT)) || (out_drive_out == -DRIVE_W'(DRIVE_LIMIT)))
    else $error("saturated flag without clamped drive");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r)
    else $error("stage 1 request lost during output stall");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) && !s1_valid_r |=> !out_valid_r)
    else $error("result without stage 1 request");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import wsip_pkg::*;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [SPEED_W-1:0] speed;
    logic                      sat;
  } drive_result_t;

  typedef struct {
    bit gains_change;
    int kp;
    int ki;
    int left;
    int right;
    int target;
    bit typed;
    int exp_drive;
    int exp_speed;
    bit exp_sat;
  } plan_row_t;

  localparam int PLAN_N = 22;
  localparam int PHASES = 8;

  // directed table; typed expectations only where they are obvious
  plan_row_t plan [PLAN_N] = '{
    '{0, 0, 0,      0,      0,      0, 1, 0, 0, 0},
    '{0, 0, 0,  32767,  32767,   4095, 0, 0, 0, 0},
    '{0, 0, 0, -32768, -32768,  -4096, 0, 0, 0, 0},
    '{0, 0, 0,  32767, -32768,      0, 0, 0, 0, 0},
    '{0, 0, 0,     -9,      7,     -1, 0, 0, 0, 0},
    '{0, 0, 0,     15,     15,    100, 0, 0, 0, 0},
    '{0, 0, 0,      0,      0,      0, 0, 0, 0, 0},
    '{0, 0, 0,      0,      0,      0, 0, 0, 0, 0},
    '{0, 0, 0,      0,      0,      0, 0, 0, 0, 0},
    '{0, 0, 0,      0,      0,      0, 0, 0, 0, 0},
    // filter has settled to zero: drive walks by ki*err
    '{1, 0, 55705,  0,      0,      1, 1,  55705, 0, 0},
    '{0, 0, 0,      0,      0,      2, 1,  55705, 0, 1},
    '{0, 0, 0,      0,      0,     -1, 1,      0, 0, 0},
    '{0, 0, 0,      0,      0,     -1, 1, -55705, 0, 0},
    '{0, 0, 0,      0,      0,     -1, 1, -55705, 0, 1},
    '{1, 65535, 65535, 32767, 32767, -4096, 0, 0, 0, 0},
    '{0, 0, 0, -32768, -32768,   4095, 0, 0, 0, 0},
    '{0, 0, 0,      0,      0,   4095, 0, 0, 0, 0},
    '{0, 0, 0,    100,   -100,      0, 0, 0, 0, 0},
    '{1, 393, 131,   80,     88,     10, 0, 0, 0, 0},
    '{0, 0, 0,     80,     80,     10, 0, 0, 0, 0},
    '{0, 0, 0,   -800,   -800,   -100, 0, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COUNT_W-1:0] in_left_count_sum = '0;
  logic signed [COUNT_W-1:0] in_right_count_sum = '0;
  logic signed [SPEED_W-1:0] in_speed_goal = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive_out;
  logic signed [SPEED_W-1:0] out_measured_speed;
  logic out_saturated;

  wheel_speed_incremental_pi_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_left_count_sum  (in_left_count_sum),
    .in_right_count_sum (in_right_count_sum),
    .in_speed_goal      (in_speed_goal),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive_out      (out_drive_out),
    .out_measured_speed (out_measured_speed),
    .out_saturated      (out_saturated)
  );

  always #1 clk = ~clk;

  // controller state mirrored here
  int kp_gain = 0;
  int ki_gain = 0;
  int filt_speed = 0;
  int last_err = 0;
  int drive_acc = 0;

  drive_result_t pending [$];
  int bad_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int clamp_seen = 0;
  int gain_settings = 0;
  int gap_pct = 20;
  int stall_pct = 20;
  int stall_cnt = 0;
  int cruise = 0;

  function automatic int fit(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int pick_edge(input int lo, input int hi);
    case ($urandom_range(0, 4))
      0: return lo;
      1: return hi;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic drive_result_t advance_pi(input int left, input int right,
                                               input int target);
    int lspd;
    int rspd;
    int avg;
    int f;
    int err;
    longint mix;
    longint acc;
    drive_result_t r;
    lspd = left / SAMPLES_PER_PERIOD;
    rspd = right / SAMPLES_PER_PERIOD;
    avg = fit((lspd + rspd) / 2, SPEED_MIN, SPEED_MAX);
    mix = longint'(W_NEW) * avg + longint'(W_OLD) * filt_speed;
    f = int'(mix / Q15_ONE);
    err = target - f;
    acc = longint'(drive_acc) + longint'(kp_gain) * (err - last_err)
        + longint'(ki_gain) * err;
    r.sat = 1'b0;
    if (acc > DRIVE_LIMIT) begin
      acc = DRIVE_LIMIT;
      r.sat = 1'b1;
    end else if (acc < -DRIVE_LIMIT) begin
      acc = -DRIVE_LIMIT;
      r.sat = 1'b1;
    end
    filt_speed = f;
    last_err = err;
    drive_acc = int'(acc);
    r.drive = DRIVE_W'(acc);
    r.speed = SPEED_W'(f);
    return r;
  endfunction

  task automatic report_bad(input string msg);
    bad_count++;
    if (bad_count <= 50) $display("%0t ns  %s", $time, msg);
  endtask

  task automatic send_request(input int left, input int right, input int target,
                              input bit typed, input int xd, input int xs,
                              input bit xsat);
    drive_result_t due;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_count_sum <= COUNT_W'(left);
    in_right_count_sum <= COUNT_W'(right);
    in_speed_goal <= SPEED_W'(target);
    do @(posedge clk); while (!in_ready);
    due = advance_pi(left, right, target);
    if (typed) begin
      due.drive = DRIVE_W'(xd);
      due.speed = SPEED_W'(xs);
      due.sat = xsat;
    end
    pending.push_back(due);
    requests_sent++;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // gains, then junk into the unused indexes, which must be ignored
  task automatic set_gains(input int kp, input int ki);
    int idx;
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PROP_GAIN;
    cfg_wdata <= CFG_DATA_W'(kp);
    @(posedge clk);
    cfg_index <= CFG_INTEG_GAIN;
    cfg_wdata <= CFG_DATA_W'(ki);
    @(posedge clk);
    for (idx = int'(CFG_INTEG_GAIN) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      cfg_index <= CFG_IDX_W'(idx);
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    kp_gain = kp;
    ki_gain = ki;
    gain_settings++;
  endtask

  task automatic run_phase(input int n);
    int i;
    int mode;
    int left;
    int right;
    int target;
    for (i = 0; i < n; i++) begin
      mode = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) cruise = int'($urandom_range(0, 8191)) - 4096;
      if (mode < 40) begin
        // wheels near the cruise speed, target close to it
        left = fit(8 * cruise + int'($urandom_range(0, 64)) - 32, -32768, 32767);
        right = fit(8 * cruise + int'($urandom_range(0, 64)) - 32, -32768, 32767);
        target = fit(cruise + int'($urandom_range(0, 40)) - 20, -4096, 4095);
      end else if (mode < 75) begin
        left = int'($urandom_range(0, 65535)) - 32768;
        right = int'($urandom_range(0, 65535)) - 32768;
        target = int'($urandom_range(0, 8191)) - 4096;
      end else if (mode < 90) begin
        left = pick_edge(-32768, 32767);
        right = pick_edge(-32768, 32767);
        target = pick_edge(-4096, 4095);
      end else begin
        left = int'($urandom_range(0, 32)) - 16;
        right = int'($urandom_range(0, 32)) - 16;
        target = int'($urandom_range(0, 16)) - 8;
      end
      send_request(left, right, target, 1'b0, 0, 0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (stall_cnt > 0) stall_cnt--;
    else if ($urandom_range(0, 99) < stall_pct) stall_cnt = $urandom_range(1, 6);
    out_ready <= (stall_cnt == 0);
  end

  always @(posedge clk) begin
    drive_result_t due;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_saturated === 1'b1) clamp_seen++;
      if (pending.size() == 0) begin
        report_bad($sformatf("result with no request pending: drive %0d speed %0d",
                             out_drive_out, out_measured_speed));
      end else begin
        due = pending.pop_front();
        if (out_drive_out !== due.drive)
          report_bad($sformatf("result %0d drive_out %0d, want %0d",
                               results_seen, out_drive_out, due.drive));
        if (out_measured_speed !== due.speed)
          report_bad($sformatf("result %0d measured_speed %0d, want %0d",
                               results_seen, out_measured_speed, due.speed));
        if (out_saturated !== due.sat)
          report_bad($sformatf("result %0d saturated %b, want %b",
                               results_seen, out_saturated, due.sat));
      end
    end
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int k;
    int ph;
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PLAN_N; k++) begin
      if (plan[k].gains_change) begin
        finish_phase();
        set_gains(plan[k].kp, plan[k].ki);
      end
      send_request(plan[k].left, plan[k].right, plan[k].target, plan[k].typed,
                   plan[k].exp_drive, plan[k].exp_speed, plan[k].exp_sat);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      finish_phase();
      if (ph == PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = (ph % 3) * 25;
        stall_pct = ((ph + 1) % 3) * 25;
      end
      case (ph)
        0: set_gains(0, 0);
        1: set_gains(65535, 65535);
        2: set_gains(393, 131);
        3: set_gains(0, 65535);
        4: set_gains(65535, 0);
        5: set_gains($urandom_range(0, 2047), $urandom_range(0, 2047));
        6: set_gains($urandom_range(0, 65535), $urandom_range(0, 65535));
        default: set_gains($urandom_range(0, 4095), $urandom_range(0, 1023));
      endcase
      run_phase(ph == PHASES - 1 ? 130 : 115);
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending.size() != 0)
      report_bad($sformatf("%0d requests never produced a result", pending.size()));

    $display("%0d requests under %0d gain settings, %0d results checked",
             requests_sent, gain_settings, results_seen);
    $display("%0d results clamped at the drive limit, %0d mismatches",
             clamp_seen, bad_count);
    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/wsip_pkg.sv
hdl/wsip_front.sv
hdl/wsip_core.sv
hdl/wheel_speed_incremental_pi_unit.sv
tb/sv/testbench.sv
